// ----- rtl/core/bws_pkg.sv -----
`default_nettype none

package bws_pkg;

    // input opcodes
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_TX    = 3'd2;
    localparam logic [2:0] OP_RX    = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NAK     = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CMD_CODE = 2'd0;
    localparam logic [1:0] CFG_ACK_CODE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    // configuration reset values
    localparam logic [7:0] CMD_CODE_RST = 8'd49;
    localparam logic [7:0] ACK_CODE_RST = 8'd121;
    localparam logic [7:0] TIMEOUT_RST  = 8'd10;

    localparam logic [7:0] COMPLEMENT_MASK = 8'hFF;
    localparam int         ADDR_BYTES      = 4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  payload_byte;
        logic [31:0] target_address;
        logic [8:0]  byte_count;
        logic [7:0]  received_byte;
    } bws_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] transmit_byte;
        logic       frame_end;
        logic [1:0] status_code;
    } bws_result_t;

    typedef struct packed {
        logic [7:0] cmd_code;
        logic [7:0] ack_code;
        logic [7:0] timeout_limit;
    } bws_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/bws_if.sv -----
`default_nettype none

interface bws_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  payload_byte;
    logic [31:0] target_address;
    logic [8:0]  byte_count;
    logic [7:0]  received_byte;

    modport source (
        output valid, opcode, payload_byte, target_address, byte_count, received_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, payload_byte, target_address, byte_count, received_byte,
        output ready
    );
endinterface

interface bws_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] transmit_byte;
    logic       frame_end;
    logic [1:0] status_code;

    modport source (
        output valid, result_kind, transmit_byte, frame_end, status_code,
        input  ready
    );
    modport sink (
        input  valid, result_kind, transmit_byte, frame_end, status_code,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/bws_mem.sv -----
`default_nettype none

module bws_mem #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0] waddr,
    input  wire logic [7:0]                      wdata,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0] raddr,
    output logic [7:0]                           rdata
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bws_out_buf.sv -----
`default_nettype none

module bws_out_buf
    import bws_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire bws_result_t  push_data,
    output logic              space,
    bws_out_if.source         out_ch
);

    logic        out_valid_reg, out_valid_next;
    bws_result_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    bws_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && out_ch.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space                = !skid_valid_reg;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.result_kind   = out_data_reg.result_kind;
    assign out_ch.transmit_byte = out_data_reg.transmit_byte;
    assign out_ch.frame_end     = out_data_reg.frame_end;
    assign out_ch.status_code   = out_data_reg.status_code;

    // a held beat in the skid stage always sits behind a shown one
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output register empty");

endmodule

`default_nettype wire

// ----- rtl/core/bws_ctrl.sv -----
`default_nettype none

module bws_ctrl
    import bws_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire bws_item_t                       item,
    input  wire bws_cfg_t                        cfg,
    output logic                                 mem_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      mem_waddr,
    output logic [7:0]                           mem_wdata,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      mem_raddr,
    input  wire logic [7:0]                      mem_rdata,
    output logic                                 res_valid,
    output bws_result_t                          res
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = $clog2(BUFFER_DEPTH + 2);

    typedef enum logic [1:0] {PH_IDLE, PH_CMD, PH_ADDR, PH_DATA} phase_t;

    phase_t        phase_reg, phase_next;
    logic          await_reg, await_next;
    logic [CW-1:0] load_idx_reg, load_idx_next;
    logic [31:0]   addr_reg, addr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] send_idx_reg, send_idx_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    ticks_reg, ticks_next;

    logic [7:0]    frame_byte;
    logic          frame_last;
    logic [SW-1:0] count_ext;
    logic [8:0]    start_count;
    logic [SW-1:0] rd_idx;

    assign count_ext = SW'(count_reg);

    // byte the current frame sends next
    always_comb
    begin
        frame_byte = 8'd0;
        frame_last = 1'b0;
        case (phase_reg)
            PH_CMD:
            begin
                if (send_idx_reg == '0)
                begin
                    frame_byte = cfg.cmd_code;
                end
                else
                begin
                    frame_byte = cfg.cmd_code ^ COMPLEMENT_MASK;
                    frame_last = 1'b1;
                end
            end
            PH_ADDR:
            begin
                if (send_idx_reg < SW'(ADDR_BYTES))
                begin
                    // big-endian: index 0 takes bits 31:24
                    frame_byte = addr_reg[{~send_idx_reg[1:0], 3'b000} +: 8];
                end
                else
                begin
                    frame_byte = xor_reg;
                    frame_last = 1'b1;
                end
            end
            PH_DATA:
            begin
                if (send_idx_reg == '0)
                begin
                    frame_byte = 8'(count_reg - CW'(1));
                end
                else if (send_idx_reg <= count_ext)
                begin
                    frame_byte = mem_rdata;
                end
                else
                begin
                    frame_byte = xor_reg;
                    frame_last = 1'b1;
                end
            end
            default:
            begin
                frame_byte = 8'd0;
                frame_last = 1'b0;
            end
        endcase
    end

    // zero counts as one, beyond the buffer counts as the buffer
    always_comb
    begin
        if (item.byte_count == 9'd0)
        begin
            start_count = 9'd1;
        end
        else if (item.byte_count > 9'(BUFFER_DEPTH))
        begin
            start_count = 9'(BUFFER_DEPTH);
        end
        else
        begin
            start_count = item.byte_count;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        await_next    = await_reg;
        load_idx_next = load_idx_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        send_idx_next = send_idx_reg;
        xor_next      = xor_reg;
        ticks_next    = ticks_reg;
        mem_we        = 1'b0;
        res_valid     = 1'b0;
        res           = '{result_kind: KIND_BYTE, transmit_byte: 8'd0,
                          frame_end: 1'b0, status_code: STAT_OK};
        if (accept)
        begin
            case (item.opcode)
                OP_LOAD:
                begin
                    if (phase_reg == PH_IDLE && load_idx_reg < CW'(BUFFER_DEPTH))
                    begin
                        mem_we        = 1'b1;
                        load_idx_next = load_idx_reg + CW'(1);
                    end
                end
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        addr_next     = item.target_address;
                        count_next    = CW'(start_count);
                        load_idx_next = '0;
                        phase_next    = PH_CMD;
                        await_next    = 1'b0;
                        send_idx_next = '0;
                        xor_next      = 8'd0;
                        ticks_next    = 8'd0;
                    end
                end
                OP_TX:
                begin
                    if (phase_reg != PH_IDLE && !await_reg)
                    begin
                        res_valid         = 1'b1;
                        res.transmit_byte = frame_byte;
                        res.frame_end     = frame_last;
                        if (frame_last)
                        begin
                            await_next    = 1'b1;
                            send_idx_next = '0;
                            xor_next      = 8'd0;
                            ticks_next    = 8'd0;
                        end
                        else
                        begin
                            xor_next      = xor_reg ^ frame_byte;
                            send_idx_next = send_idx_reg + SW'(1);
                        end
                    end
                end
                OP_RX:
                begin
                    if (phase_reg != PH_IDLE && await_reg)
                    begin
                        await_next    = 1'b0;
                        send_idx_next = '0;
                        xor_next      = 8'd0;
                        ticks_next    = 8'd0;
                        if (item.received_byte != cfg.ack_code)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_STATUS;
                            res.status_code = STAT_NAK;
                            phase_next      = PH_IDLE;
                        end
                        else if (phase_reg == PH_DATA)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_STATUS;
                            res.status_code = STAT_OK;
                            phase_next      = PH_IDLE;
                        end
                        else if (phase_reg == PH_CMD)
                        begin
                            phase_next = PH_ADDR;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE && await_reg)
                    begin
                        ticks_next = ticks_reg + 8'd1;
                        if (ticks_next == cfg.timeout_limit)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_STATUS;
                            res.status_code = STAT_TIMEOUT;
                            phase_next      = PH_IDLE;
                            await_next      = 1'b0;
                            send_idx_next   = '0;
                            xor_next        = 8'd0;
                            ticks_next      = 8'd0;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // prefetch the payload entry that the next send index will need
    assign rd_idx    = send_idx_next - SW'(1);
    assign mem_raddr = rd_idx[AW-1:0];
    assign mem_waddr = load_idx_reg[AW-1:0];
    assign mem_wdata = item.payload_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            await_reg    <= 1'b0;
            load_idx_reg <= '0;
            addr_reg     <= 32'd0;
            count_reg    <= '0;
            send_idx_reg <= '0;
            xor_reg      <= 8'd0;
            ticks_reg    <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            await_reg    <= await_next;
            load_idx_reg <= load_idx_next;
            addr_reg     <= addr_next;
            count_reg    <= count_next;
            send_idx_reg <= send_idx_next;
            xor_reg      <= xor_next;
            ticks_reg    <= ticks_next;
        end
    end

    a_await_busy: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> phase_reg != PH_IDLE)
        else $error("waiting for a reply while idle");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> phase_reg == PH_IDLE)
        else $error("payload buffer written during an exchange");

    a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == KIND_STATUS |=> phase_reg == PH_IDLE && !await_reg)
        else $error("exchange still running after its status");

endmodule

`default_nettype wire

// ----- rtl/core/bootloader_write_sequencer.sv -----
// host side of a serial bootloader write-memory exchange
//
// in_ch carries one beat per event: load payload byte, start, transmit slot
// free, received byte, or tick. out_ch carries transmit bytes (with a frame
// end mark) and the final status of an exchange. cfg_we/cfg_index/cfg_wdata
// write the command code, the ack code and the timeout limit.
//
// one beat is accepted per cycle while the skid stage has room; a result is
// registered before it shows on out_ch. the payload buffer is a synchronous
// ram; the next data byte is prefetched every cycle: no transmit slot waits.
//
// reset puts the sequencer idle with load and send indexes at zero and the
// config registers at their defaults. the payload buffer is not cleared, so
// a count beyond the bytes loaded sends whatever older entries hold.
//
// when out_ch stalls, one result waits in the output register and one more
// in a skid stage; in_ch.ready drops only once the skid stage is full.
`default_nettype none

module bootloader_write_sequencer
    import bws_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    bws_in_if.sink          in_ch,
    bws_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    bws_cfg_t    cfg_reg;
    bws_item_t   item;
    bws_result_t res;
    logic        res_valid;
    logic        space;
    logic        accept;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_rdata;

    // config registers: user writes only while sequencer is quiet; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd_code      <= CMD_CODE_RST;
            cfg_reg.ack_code      <= ACK_CODE_RST;
            cfg_reg.timeout_limit <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CMD_CODE: cfg_reg.cmd_code      <= cfg_wdata;
                CFG_ACK_CODE: cfg_reg.ack_code      <= cfg_wdata;
                CFG_TIMEOUT:  cfg_reg.timeout_limit <= cfg_wdata;
                default:      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // a beat is taken whenever the skid stage has room
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    assign item = '{opcode:         in_ch.opcode,
                    payload_byte:   in_ch.payload_byte,
                    target_address: in_ch.target_address,
                    byte_count:     in_ch.byte_count,
                    received_byte:  in_ch.received_byte};

    bws_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg       (cfg_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // payload buffer, one write and one registered read per cycle
    bws_mem #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register plus skid stage
    bws_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

// ----- tb/bootloader_write_sequencer_test.sv -----
`timescale 1ns / 1ps

module bootloader_write_sequencer_test;
    import bws_pkg::*;

    localparam int BUF_DEPTH      = 256;
    // settle time after the last expected result has been seen
    localparam int SETTLE_CYCLES  = 4;
    // cycles without any accepted beat before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    // exchange phases of the predictor
    typedef enum logic [1:0] {SEQ_IDLE, SEQ_CMD, SEQ_ADDR, SEQ_DATA} seq_phase_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;

    bws_in_if  in_ch ();
    bws_out_if out_ch ();

    bootloader_write_sequencer #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the configuration
    logic [7:0] cfg_cmd;
    logic [7:0] cfg_ack;
    logic [7:0] cfg_tmo;

    // predictor copy of the exchange state
    seq_phase_t ex_phase;
    bit         ex_waiting;
    logic [7:0] ex_buf [BUF_DEPTH];
    int         ex_fill;
    logic [31:0] ex_addr;
    int         ex_count;
    int         ex_pos;
    logic [7:0] ex_xor;
    logic [7:0] ex_ticks;

    // result beats predicted but not yet seen on out_ch
    bws_result_t pending_results [$];

    int fail_count;
    int idle_cycles;
    int burst_left;
    bit tx_steady;
    bit rx_steady;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // clear the per-frame counters
    function automatic void rewind_frame();
        ex_waiting = 1'b0;
        ex_pos     = 0;
        ex_xor     = '0;
        ex_ticks   = '0;
    endfunction

    // end of the exchange: a status beat and back to idle
    function automatic void close_exchange(input logic [1:0] code, output bws_result_t res);
        res               = '0;
        res.result_kind   = KIND_STATUS;
        res.transmit_byte = '0;
        res.frame_end     = 1'b0;
        res.status_code   = code;
        ex_phase          = SEQ_IDLE;
        rewind_frame();
    endfunction

    // one accepted beat in, at most one expected result beat out
    function automatic void predict_sequencer_beat(input bws_item_t it, output bit has_res,
                                                   output bws_result_t res);
        logic [7:0] b;
        bit         last;
        int         n;
        has_res = 1'b0;
        res     = '0;
        b       = '0;
        last    = 1'b0;
        case (it.opcode)
            OP_LOAD:
            begin
                // loads only land while idle and below the top of the buffer
                if (ex_phase == SEQ_IDLE && ex_fill < BUF_DEPTH)
                begin
                    ex_buf[ex_fill] = it.payload_byte;
                    ex_fill++;
                end
            end
            OP_START:
            begin
                if (ex_phase == SEQ_IDLE)
                begin
                    // zero count acts as one, oversize counts clip to the buffer
                    n = it.byte_count;
                    if (n == 0)
                        n = 1;
                    if (n > BUF_DEPTH)
                        n = BUF_DEPTH;
                    ex_addr  = it.target_address;
                    ex_count = n;
                    ex_fill  = 0;
                    rewind_frame();
                    ex_phase = SEQ_CMD;
                end
            end
            OP_TX:
            begin
                if (ex_phase != SEQ_IDLE && !ex_waiting)
                begin
                    case (ex_phase)
                        SEQ_CMD:
                        begin
                            if (ex_pos == 0)
                                b = cfg_cmd;
                            else
                            begin
                                b    = cfg_cmd ^ COMPLEMENT_MASK;
                                last = 1'b1;
                            end
                        end
                        SEQ_ADDR:
                        begin
                            // big-endian address, then the xor of its bytes
                            if (ex_pos < ADDR_BYTES)
                                b = ex_addr[8 * (ADDR_BYTES - 1 - ex_pos) +: 8];
                            else
                            begin
                                b    = ex_xor;
                                last = 1'b1;
                            end
                        end
                        default:
                        begin
                            // length-1, payload, then xor over both
                            if (ex_pos == 0)
                                b = 8'(ex_count - 1);
                            else if (ex_pos <= ex_count)
                                b = ex_buf[ex_pos - 1];
                            else
                            begin
                                b    = ex_xor;
                                last = 1'b1;
                            end
                        end
                    endcase
                    has_res           = 1'b1;
                    res.result_kind   = KIND_BYTE;
                    res.transmit_byte = b;
                    res.frame_end     = last;
                    res.status_code   = STAT_OK;
                    if (last)
                    begin
                        rewind_frame();
                        ex_waiting = 1'b1;
                    end
                    else
                    begin
                        ex_xor = ex_xor ^ b;
                        ex_pos++;
                    end
                end
            end
            OP_RX:
            begin
                if (ex_phase != SEQ_IDLE && ex_waiting)
                begin
                    has_res = 1'b1;
                    if (it.received_byte != cfg_ack)
                        close_exchange(STAT_NAK, res);
                    else if (ex_phase == SEQ_DATA)
                        close_exchange(STAT_OK, res);
                    else
                    begin
                        has_res  = 1'b0;
                        ex_phase = seq_phase_t'(ex_phase + 1);
                        rewind_frame();
                    end
                end
            end
            OP_TICK:
            begin
                if (ex_phase != SEQ_IDLE && ex_waiting)
                begin
                    // 8-bit counter, so a zero limit means 256 ticks
                    ex_ticks = ex_ticks + 8'd1;
                    if (ex_ticks == cfg_tmo)
                    begin
                        has_res = 1'b1;
                        close_exchange(STAT_TIMEOUT, res);
                    end
                end
            end
            default:
            begin
                // unused opcodes do nothing
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // beat driver and helpers
    // ------------------------------------------------------------------

    // drive one beat at the falling edge, hold until accepted, then predict
    task automatic send_beat(input bws_item_t it);
        int          gap;
        bit          has_res;
        bws_result_t res;
        if (!tx_steady)
        begin
            // bursts of random length separated by random gaps
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge clk);
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= it.opcode;
        in_ch.payload_byte   <= it.payload_byte;
        in_ch.target_address <= it.target_address;
        in_ch.byte_count     <= it.byte_count;
        in_ch.received_byte  <= it.received_byte;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_sequencer_beat(it, has_res, res);
        if (has_res)
            pending_results.push_back(res);
    endtask

    // one beat of the given opcode; unused fields carry random filler
    task automatic send_op(input logic [2:0] op, input logic [31:0] addr, input logic [8:0] arg);
        bws_item_t it;
        it.opcode         = op;
        it.payload_byte   = 8'($urandom);
        it.target_address = $urandom;
        it.byte_count     = 9'($urandom);
        it.received_byte  = 8'($urandom);
        case (op)
            OP_LOAD:  it.payload_byte = arg[7:0];
            OP_START:
            begin
                it.target_address = addr;
                it.byte_count     = arg;
            end
            OP_RX:    it.received_byte = arg[7:0];
            default:  ;
        endcase
        send_beat(it);
    endtask

    // transmit slots until the current frame is out
    task automatic send_frame();
        while (ex_phase != SEQ_IDLE && !ex_waiting)
            send_op(OP_TX, '0, '0);
    endtask

    // drive well-formed beats until the exchange is over
    task automatic finish_exchange();
        while (ex_phase != SEQ_IDLE)
        begin
            if (ex_waiting)
                send_op(OP_RX, '0, {1'b0, cfg_ack});
            else
                send_op(OP_TX, '0, '0);
        end
    endtask

    // drop valid, wait for every expected beat, then let the pipe settle
    task automatic quiesce();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        quiesce();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CMD_CODE: cfg_cmd = val;
            CFG_ACK_CODE: cfg_ack = val;
            CFG_TIMEOUT:  cfg_tmo = val;
            default:      ;
        endcase
    endtask

    // mostly well-formed traffic driven by the predicted state, some noise
    function automatic bws_item_t pick_random_beat();
        bws_item_t it;
        int        roll;
        int        size_roll;
        roll      = $urandom_range(0, 99);
        size_roll = $urandom_range(0, 99);
        it.payload_byte   = 8'($urandom);
        it.target_address = $urandom;
        it.received_byte  = 8'($urandom);
        // small sizes dominate, full buffer and oversize are rare
        if (size_roll < 80)
            it.byte_count = 9'($urandom_range(1, 8));
        else if (size_roll < 92)
            it.byte_count = 9'($urandom_range(9, 40));
        else if (size_roll < 98)
            it.byte_count = '0;
        else if (size_roll == 98)
            it.byte_count = 9'(BUF_DEPTH);
        else
            it.byte_count = 9'($urandom_range(BUF_DEPTH + 1, 511));
        if (roll < 8)
            it.opcode = 3'($urandom_range(0, 7));
        else if (ex_phase == SEQ_IDLE)
            it.opcode = (roll < 40) ? OP_LOAD : OP_START;
        else if (!ex_waiting)
        begin
            if (roll < 92)
                it.opcode = OP_TX;
            else
                it.opcode = 3'($urandom_range(0, 4));
        end
        else
        begin
            if (roll < 14)
                it.opcode = OP_TX;
            else if (roll < 45)
                it.opcode = OP_TICK;
            else
            begin
                it.opcode = OP_RX;
                if (roll < 93)
                    it.received_byte = cfg_ack;
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // short exchange with reset config and extreme payload values
    task automatic test_basic_exchange();
        send_op(OP_LOAD, '0, 9'h000);
        send_op(OP_LOAD, '0, 9'h0FF);
        send_op(OP_LOAD, '0, 9'h0A5);
        send_op(OP_LOAD, '0, 9'h05A);
        send_op(OP_START, 32'h1234_5678, 9'd4);
        repeat (3)
        begin
            send_frame();
            send_op(OP_RX, '0, {1'b0, cfg_ack});
        end
        quiesce();
    endtask

    // fill the whole buffer, overflow it, then oversize and zero counts
    task automatic test_full_buffer();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (BUF_DEPTH + 1) send_op(OP_LOAD, '0, 9'($urandom));
        send_op(OP_START, 32'hFFFF_FFFF, 9'd300);
        finish_exchange();
        send_op(OP_START, 32'h0000_0000, 9'd0);
        finish_exchange();
        send_op(OP_START, 32'h8000_0001, 9'd256);
        finish_exchange();
        quiesce();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // beats that must be ignored, tx slots while waiting, negative reply
    task automatic test_ignored_beats();
        logic [2:0] op;
        send_op(OP_TX, '0, '0);
        send_op(OP_RX, '0, {1'b0, cfg_ack});
        send_op(OP_TICK, '0, '0);
        for (op = 3'd5; op != 3'd0; op++)
            send_op(op, $urandom, 9'($urandom));
        send_op(OP_START, 32'hA5A5_5A5A, 9'd2);
        // busy: load, start, reply and tick before the frame is out
        send_op(OP_LOAD, '0, 9'h0C3);
        send_op(OP_START, 32'h0, 9'd7);
        send_op(OP_RX, '0, {1'b0, cfg_ack});
        send_op(OP_TICK, '0, '0);
        send_op(3'd7, '0, '0);
        send_frame();
        send_op(OP_TX, '0, '0);
        send_op(OP_TX, '0, '0);
        send_op(OP_TICK, '0, '0);
        send_op(OP_RX, '0, {1'b0, cfg_ack});
        send_frame();
        send_op(OP_RX, '0, {1'b0, cfg_ack ^ 8'h01});
        quiesce();
    endtask

    // register extremes, fastest timeout and wrapped zero timeout
    task automatic test_config_extremes();
        write_reg(CFG_CMD_CODE, 8'h00);
        write_reg(CFG_ACK_CODE, 8'hFF);
        write_reg(CFG_TIMEOUT, 8'd1);
        send_op(OP_START, 32'h0000_0000, 9'd1);
        send_frame();
        send_op(OP_RX, '0, 9'h0FF);
        send_frame();
        send_op(OP_TICK, '0, '0);

        write_reg(CFG_CMD_CODE, 8'hFF);
        write_reg(CFG_ACK_CODE, 8'h00);
        write_reg(CFG_TIMEOUT, 8'd255);
        send_op(OP_START, 32'hFFFF_FFFF, 9'd5);
        finish_exchange();

        // zero limit: the counter wraps, timeout after 256 ticks
        write_reg(CFG_TIMEOUT, 8'd0);
        send_op(OP_START, 32'h0F0F_F0F0, 9'd3);
        send_frame();
        repeat (256) send_op(OP_TICK, '0, '0);
        quiesce();
    endtask

    // one random phase under a given config and handshake style
    task automatic random_phase(input logic [7:0] cmd, input logic [7:0] ack,
                                input logic [7:0] tmo, input bit steady, input int beats);
        write_reg(CFG_CMD_CODE, cmd);
        write_reg(CFG_ACK_CODE, ack);
        write_reg(CFG_TIMEOUT, tmo);
        tx_steady = steady;
        rx_steady = steady;
        repeat (beats) send_beat(pick_random_beat());
        finish_exchange();
        quiesce();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase(CMD_CODE_RST, ACK_CODE_RST, TIMEOUT_RST, 1'b0, 100);
        random_phase(8'($urandom), 8'($urandom), 8'($urandom_range(1, 6)), 1'b0, 100);
        random_phase(8'($urandom), 8'($urandom), 8'd1, 1'b1, 100);
        random_phase(8'($urandom), 8'($urandom), 8'd255, 1'b0, 100);
    endtask

    // ------------------------------------------------------------------
    // receiver: ready runs and stalls of random length, rare long stalls
    // ------------------------------------------------------------------
    initial
    begin
        int run;
        int stall;
        out_ch.ready = 1'b0;
        forever
        begin
            run = rx_steady ? 1 : $urandom_range(1, 10);
            repeat (run)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            if (!rx_steady)
            begin
                stall = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                    : $urandom_range(1, 5);
                repeat (stall)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // checker: every result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bws_result_t exp_res;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: kind %0d byte %0h end %0d status %0d",
                       out_ch.result_kind, out_ch.transmit_byte, out_ch.frame_end,
                       out_ch.status_code);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (out_ch.result_kind !== exp_res.result_kind)
                begin
                    $error("result_kind: expected %0d, actual %0d",
                           exp_res.result_kind, out_ch.result_kind);
                    fail_count++;
                end
                if (out_ch.transmit_byte !== exp_res.transmit_byte)
                begin
                    $error("transmit_byte: expected %0h, actual %0h",
                           exp_res.transmit_byte, out_ch.transmit_byte);
                    fail_count++;
                end
                if (out_ch.frame_end !== exp_res.frame_end)
                begin
                    $error("frame_end: expected %0d, actual %0d",
                           exp_res.frame_end, out_ch.frame_end);
                    fail_count++;
                end
                if (out_ch.status_code !== exp_res.status_code)
                begin
                    $error("status_code: expected %0d, actual %0d",
                           exp_res.status_code, out_ch.status_code);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: no beat accepted on either side for too long means a hang
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        fail_count  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;

        in_ch.valid          = 1'b0;
        in_ch.opcode         = OP_LOAD;
        in_ch.payload_byte   = '0;
        in_ch.target_address = '0;
        in_ch.byte_count     = '0;
        in_ch.received_byte  = '0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_CMD_CODE;
        cfg_wdata            = '0;

        // predictor state after reset
        cfg_cmd  = CMD_CODE_RST;
        cfg_ack  = ACK_CODE_RST;
        cfg_tmo  = TIMEOUT_RST;
        ex_phase = SEQ_IDLE;
        ex_fill  = 0;
        ex_addr  = '0;
        ex_count = 0;
        rewind_frame();

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_exchange();
        test_full_buffer();
        test_ignored_beats();
        test_config_extremes();
        test_random_traffic();

        quiesce();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bws_pkg.sv
rtl/core/bws_if.sv
rtl/core/bws_mem.sv
rtl/core/bws_out_buf.sv
rtl/core/bws_ctrl.sv
rtl/core/bootloader_write_sequencer.sv
tb/bootloader_write_sequencer_test.sv
